// ===== rtl/text_console_writer_defines.svh =====
// Assertion macros for the text console writer.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef SYNTH
`define TCW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text console check failed");
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text console check failed");
`else
`define TCW_ASSERT_SAME(label, ante, cons)
`define TCW_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int ADDR_FIELD_W = 11;
    localparam int COL_FIELD_W = 7;
    localparam int ROW_FIELD_W = 5;
    localparam int CELL_W      = 16;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

    localparam logic REG_TEXT_ATTR = 1'b0;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_BKSP  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_READ  = 2'd3
    } tcw_mode_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SWEEP,
        ST_DONE
    } tcw_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic read_capture;
        logic sweep_step;
        logic load_out;
    } tcw_cmd_t;

    typedef struct packed {
        tcw_mode_t mode;
        logic      scroll_needed;
        logic      sweep_last;
        logic      out_free;
    } tcw_status_t;

endpackage

// ===== rtl/tcw_ifs.sv =====
// Valid/ready channel interfaces for console items and results.
interface tcw_in_if;
    import tcw_pkg::*;
    logic                    valid;
    logic                    ready;
    tcw_mode_t               mode;
    logic [CHAR_W-1:0]       char_code;
    logic [ADDR_FIELD_W-1:0] cell_address;

    modport source (output valid, mode, char_code, cell_address, input ready);
    modport sink (input valid, mode, char_code, cell_address, output ready);
endinterface

interface tcw_out_if;
    import tcw_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [COL_FIELD_W-1:0] cursor_column;
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic [CELL_W-1:0]      cell_value;
    logic                   scrolled;

    modport source (output valid, cursor_column, cursor_row, cell_value, scrolled,
                    input ready);
    modport sink (input valid, cursor_column, cursor_row, cell_value, scrolled,
                  output ready);
endinterface

// ===== rtl/tcw_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/tcw_ctrl.sv =====
// Controller state machine: sequences accept, execute, read, sweep and result.
module tcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t    cmd
);
    import tcw_pkg::*;

    tcw_state_t state_reg;
    tcw_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                unique case (status.mode)
                    MODE_PUT:   state_next = status.scroll_needed ? ST_SWEEP : ST_DONE;
                    MODE_BKSP:  state_next = ST_DONE;
                    MODE_CLEAR: state_next = ST_SWEEP;
                    MODE_READ:  state_next = ST_READ;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_READ:
            begin
                cmd.read_capture = 1'b1;
                state_next       = ST_DONE;
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

// ===== rtl/tcw_datapath.sv =====
// Datapath: cursor, scroll offset, sweep counter, screen RAM and result register.
module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tcw_pkg::tcw_cmd_t                 cmd,
    output tcw_pkg::tcw_status_t              status,
    input  tcw_pkg::tcw_mode_t                mode,
    input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
    input  logic [tcw_pkg::ADDR_FIELD_W-1:0]  cell_address,
    input  logic [tcw_pkg::ATTR_W-1:0]        attr,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [tcw_pkg::COL_FIELD_W-1:0]   cursor_column,
    output logic [tcw_pkg::ROW_FIELD_W-1:0]   cursor_row,
    output logic [tcw_pkg::CELL_W-1:0]        cell_value,
    output logic                              scrolled
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam logic [ADDR_W:0]   CELLS_X   = (ADDR_W + 1)'(CELL_COUNT);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

    // logical to physical cell index through the circular top-row offset
    function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] lin,
                                               input logic [ADDR_W-1:0] off);
        logic [ADDR_W:0] s;
        s = {1'b0, lin} + {1'b0, off};
        if (s >= CELLS_X)
        begin
            s = s - CELLS_X;
        end
        return s[ADDR_W-1:0];
    endfunction

    tcw_mode_t               mode_reg;
    logic [CHAR_W-1:0]       char_reg;
    logic [ADDR_FIELD_W-1:0] addr_reg;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] lin_reg, lin_next;
    logic [ADDR_W-1:0] off_reg, off_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              scroll_reg, scroll_next;
    logic [CELL_W-1:0] cell_reg, cell_next;

    logic              out_valid_reg, out_valid_next;
    logic [COL_FIELD_W-1:0] out_col_reg;
    logic [ROW_FIELD_W-1:0] out_row_reg;
    logic [CELL_W-1:0]      out_cell_reg;
    logic                   out_scroll_reg;

    logic              is_nl;
    logic              row_adv;
    logic              in_range;
    logic [ADDR_W:0]   off_plus;
    logic [ADDR_W-1:0] off_wrap;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_lin;
    logic [CELL_W-1:0] wr_data;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] rd_data;

    assign is_nl    = (char_reg == NEWLINE_CODE);
    assign row_adv  = is_nl || (col_reg == LAST_COL);
    assign in_range = 32'(addr_reg) < CELL_COUNT;
    assign off_plus = {1'b0, off_reg} + {1'b0, COLS_A};
    assign off_wrap = (off_plus >= CELLS_X) ? ADDR_W'(off_plus - CELLS_X)
                                            : off_plus[ADDR_W-1:0];

    assign status.mode          = mode_reg;
    assign status.scroll_needed = (mode_reg == MODE_PUT) && row_adv && (row_reg == LAST_ROW);
    assign status.sweep_last    = (sweep_reg == LAST_CELL);
    assign status.out_free      = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            char_reg <= char_code;
            addr_reg <= cell_address;
        end
    end

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        lin_next    = lin_reg;
        off_next    = off_reg;
        sweep_next  = sweep_reg;
        scroll_next = scroll_reg;
        cell_next   = cell_reg;
        wr_en       = 1'b0;
        wr_lin      = lin_reg;
        wr_data     = '0;
        if (cmd.exec)
        begin
            scroll_next = 1'b0;
            cell_next   = '0;
            if (mode_reg == MODE_PUT)
            begin
                if (!is_nl)
                begin
                    wr_en   = 1'b1;
                    wr_data = {attr, char_reg};
                end
                if (row_adv)
                begin
                    col_next = '0;
                    if (row_reg == LAST_ROW)
                    begin
                        lin_next    = LAST_BASE;
                        off_next    = off_wrap;
                        sweep_next  = LAST_BASE;
                        scroll_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                        lin_next = lin_reg - ADDR_W'(col_reg) + COLS_A;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                    lin_next = lin_reg + 1'b1;
                end
            end
            else if (mode_reg == MODE_BKSP)
            begin
                if (col_reg != '0)
                begin
                    wr_en    = 1'b1;
                    wr_lin   = lin_reg - 1'b1;
                    wr_data  = {attr, SPACE_CODE};
                    col_next = col_reg - 1'b1;
                    lin_next = lin_reg - 1'b1;
                end
            end
            else if (mode_reg == MODE_CLEAR)
            begin
                col_next   = '0;
                row_next   = '0;
                lin_next   = '0;
                off_next   = '0;
                sweep_next = '0;
            end
        end
        if (cmd.read_capture)
        begin
            cell_next = in_range ? rd_data : '0;
        end
        if (cmd.sweep_step)
        begin
            wr_en      = 1'b1;
            wr_lin     = sweep_reg;
            wr_data    = '0;
            sweep_next = sweep_reg + 1'b1;
        end
    end

    assign wr_addr = phys(wr_lin, off_reg);
    assign rd_addr = phys(ADDR_W'(addr_reg), off_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            lin_reg       <= '0;
            off_reg       <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            lin_reg       <= lin_next;
            off_reg       <= off_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scroll_reg <= scroll_next;
        cell_reg   <= cell_next;
        if (cmd.load_out)
        begin
            out_col_reg    <= COL_FIELD_W'(col_reg);
            out_row_reg    <= ROW_FIELD_W'(row_reg);
            out_cell_reg   <= cell_reg;
            out_scroll_reg <= scroll_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_column = out_col_reg;
    assign cursor_row    = out_row_reg;
    assign cell_value    = out_cell_reg;
    assign scrolled      = out_scroll_reg;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ===== rtl/text_console_writer.sv =====
// Text console writer top level: one item at a time, with a registered result.
// Put and backspace run through the execute and done states; a read adds a read state
// after execute. A new item is accepted only after the done state loads the result.
// A scroll adds a zero sweep of the bottom row over the single RAM write port.
// Clear adds a zero sweep of the full screen, all COLUMNS*ROWS cells.
// After reset the screen RAM is swept to zero, all COLUMNS*ROWS cells, before
// the first item is accepted; configuration writes are taken throughout.
`include "text_console_writer_defines.svh"

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tcw_in_if.sink                         in_ch,
    tcw_out_if.source                      out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]    paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]    pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] attr_reg;
    logic [ATTR_W-1:0] attr_next;
    logic              attr_sel;
    tcw_cmd_t          cmd;
    tcw_status_t       status;
    logic              at_scroll_pos;

    assign pready   = 1'b1;
    assign attr_sel = (paddr[PADDR_W-1] == REG_TEXT_ATTR);
    assign prdata   = attr_sel ? PDATA_W'(attr_reg) : '0;

    always_comb
    begin
        attr_next = attr_reg;
        if (psel && penable && pwrite && pready && attr_sel)
        begin
            attr_next = pwdata[ATTR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else
        begin
            attr_reg <= attr_next;
        end
    end

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .mode          (in_ch.mode),
        .char_code     (in_ch.char_code),
        .cell_address  (in_ch.cell_address),
        .attr          (attr_reg),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .cursor_column (out_ch.cursor_column),
        .cursor_row    (out_ch.cursor_row),
        .cell_value    (out_ch.cell_value),
        .scrolled      (out_ch.scrolled)
    );

    assign at_scroll_pos = (out_ch.cursor_column == '0)
                        && (out_ch.cursor_row == ROW_FIELD_W'(ROWS - 1));

    `TCW_ASSERT_NEXT(a_one_item, in_ch.valid && in_ch.ready, !in_ch.ready)
    `TCW_ASSERT_SAME(a_col_range, out_ch.valid, 32'(out_ch.cursor_column) < COLUMNS)
    `TCW_ASSERT_SAME(a_scroll_pos, out_ch.valid && out_ch.scrolled, at_scroll_pos)
    `TCW_ASSERT_SAME(a_scroll_zero, out_ch.valid && out_ch.scrolled, out_ch.cell_value == '0)

endmodule
